/* rtl/mwo_pkg.sv */
// Shared types, constants and the quarter-wave sine function of the oscillator.
// Used by every module of the block but mwo_ram; depends on nothing.
package mwo_pkg;

    localparam int WINDOW_MAX_DEF      = 1024;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int PHASE_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int CFG_W       = 32;
    localparam int WLEN_W      = 11;
    localparam int STATE_DEPTH = 2;

    localparam logic [PHASE_W-1:0] QUARTER_CYCLE = 32'h4000_0000;
    localparam logic [WLEN_W-1:0]  WLEN_RESET    = 11'd1024;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_COSINE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SQUARE   = 3'd3,
        WAVE_SAWTOOTH = 3'd4
    } wave_t;

    typedef enum logic [1:0] {
        CFG_PHASE_STEP    = 2'd0,
        CFG_START_PHASE   = 2'd1,
        CFG_WAVE_SELECT   = 2'd2,
        CFG_WINDOW_LENGTH = 2'd3
    } cfg_reg_t;

    // One sample on its way from the phase stage to the shaping stages.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [2:0]         wave;
        logic [INDEX_W-1:0] index;
        logic               last;
    } phase_word_t;

    // sin(pi/2 * u) for u in Q30 (0..1), result in Q30, truncating products.
    // Only evaluated at elaboration to build the quarter-wave table.
    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] s;
        logic [63:0] r;
        s = (u * u) >> 30;
        r = 64'd3864;
        r = 64'd172273     - ((r * s) >> 30);
        r = 64'd5026995    - ((r * s) >> 30);
        r = 64'd85569306   - ((r * s) >> 30);
        r = 64'd693598668  - ((r * s) >> 30);
        r = 64'd1686629713 - ((r * s) >> 30);
        return (r * u) >> 30;
    endfunction

endpackage

/* rtl/multi_waveform_oscillator.sv */
// Multi-waveform DDS oscillator, top level: configuration registers, phase stage
// and shaping stages. Uses mwo_pkg, mwo_state, mwo_shape.
//
// Usage: each word accepted on the s_ side (bit 0 = restart) produces exactly one
// sample word on the m_ side. The phase of a sample is start_phase plus the phase
// accumulator, which grows by phase_step per sample and returns to zero after the
// last sample of a window (m_tlast) or when restart is set on the incoming word.
// Shapes: sine, cosine, triangle, square, sawtooth; other selections give sine.
// Sine comes from a quarter-wave table indexed by the top SINE_TABLE_BITS phase bits.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// A sample passes the phase register, the middle shaping register and the output register before it shows on m_tvalid.
// Throughput: one sample per cycle while m_tready does not stall; the index and
// accumulator live in a small RAM whose registered read is bypassed by forwarding,
// so back-to-back words run at full rate. Each stage holds its word when the next one is full, so a stall
// on m_tready fills the three stages and then drops s_tready; a waiting output
// never blocks a new word while an earlier stage is empty.
// Reset clears the index and accumulator, all valid flags and the registers
// (step 0, start phase 0, sine, window of 1024).
module multi_waveform_oscillator
    import mwo_pkg::*;
#(
    parameter int WINDOW_MAX      = WINDOW_MAX_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [7:0]                              s_tdata,  // [0] restart
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // sample, sample_index (10 bits), zero fill
    output logic [((SAMPLE_BITS+INDEX_W+7)/8)*8-1:0] m_tdata,
    output logic                                    m_tlast,
    input  logic                                    cfg_we,
    input  logic [1:0]                              cfg_index,
    input  logic [CFG_W-1:0]                        cfg_data
);

    localparam int DATA_W = ((SAMPLE_BITS + INDEX_W + 7) / 8) * 8;

    logic [PHASE_W-1:0]     phase_step_reg;
    logic [PHASE_W-1:0]     start_phase_reg;
    logic [2:0]             wave_reg;
    logic [WLEN_W-1:0]      wlen_reg;
    logic                   word_valid;
    logic                   word_ready;
    phase_word_t            word;
    logic [SAMPLE_BITS-1:0] sample;
    logic [INDEX_W-1:0]     sample_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= '0;
            start_phase_reg <= '0;
            wave_reg        <= WAVE_SINE;
            wlen_reg        <= WLEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PHASE_STEP:    phase_step_reg  <= cfg_data;
                CFG_START_PHASE:   start_phase_reg <= cfg_data;
                CFG_WAVE_SELECT:   wave_reg        <= cfg_data[2:0];
                CFG_WINDOW_LENGTH: wlen_reg        <= cfg_data[WLEN_W-1:0];
                default:           wlen_reg        <= wlen_reg;
            endcase
        end
    end

    mwo_state #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .restart       (s_tdata[0]),
        .phase_step    (phase_step_reg),
        .start_phase   (start_phase_reg),
        .wave          (wave_reg),
        .window_length (wlen_reg),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .word          (word)
    );

    mwo_shape #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_shape (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .word         (word),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .sample       (sample),
        .sample_index (sample_index),
        .last         (m_tlast)
    );

    assign m_tdata = DATA_W'({sample_index, sample});

endmodule

/* rtl/mwo_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Read-first: a read and a write to the same address in one cycle return old data.
module mwo_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mwo_state.sv */
// Phase stage: keeps the sample index and phase accumulator in a small RAM,
// forms the phase of each accepted sample and the window bookkeeping. Uses mwo_pkg, mwo_ram.
module mwo_state
    import mwo_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    input  logic [PHASE_W-1:0] phase_step,
    input  logic [PHASE_W-1:0] start_phase,
    input  logic [2:0]         wave,
    input  logic [WLEN_W-1:0]  window_length,
    output logic               word_valid,
    input  logic               word_ready,
    output phase_word_t        word
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int ST_W  = IDX_W + PHASE_W;

    logic [ST_W-1:0]    ram_rdata;
    logic [ST_W-1:0]    fwd_reg;
    logic               init_reg;
    logic               wr_last_reg;
    logic [ST_W-1:0]    cur_state;
    logic [IDX_W-1:0]   cur_idx;
    logic [PHASE_W-1:0] cur_acc;
    logic [IDX_W-1:0]   use_idx;
    logic [PHASE_W-1:0] use_acc;
    logic [IDX_W-1:0]   idx_next;
    logic [PHASE_W-1:0] acc_next;
    logic [31:0]        len32;
    logic               is_last;
    logic               accept;
    logic               word_valid_reg;
    phase_word_t        word_reg;

    assign in_ready = !word_valid_reg || word_ready;
    assign accept   = in_valid && in_ready;

    // The registered RAM read misses the word just written, so that word is forwarded.
    always_comb
    begin
        if (!init_reg)
        begin
            cur_state = '0;
        end
        else if (wr_last_reg)
        begin
            cur_state = fwd_reg;
        end
        else
        begin
            cur_state = ram_rdata;
        end
        cur_idx = cur_state[ST_W-1:PHASE_W];
        cur_acc = cur_state[PHASE_W-1:0];
        use_idx = restart ? '0 : cur_idx;
        use_acc = restart ? '0 : cur_acc;

        if (window_length == '0)
        begin
            len32 = 32'd1;
        end
        else if (32'(window_length) > 32'(WINDOW_MAX))
        begin
            len32 = 32'(WINDOW_MAX);
        end
        else
        begin
            len32 = 32'(window_length);
        end
        is_last  = 32'(use_idx) >= (len32 - 32'd1);
        idx_next = is_last ? '0 : use_idx + IDX_W'(1);
        acc_next = is_last ? '0 : use_acc + phase_step;
    end

    mwo_ram #(
        .WIDTH (ST_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (1'b0),
        .wdata ({idx_next, acc_next}),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg       <= 1'b0;
            wr_last_reg    <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            wr_last_reg <= accept;
            if (accept)
            begin
                init_reg <= 1'b1;
            end
            if (in_ready)
            begin
                word_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_reg        <= {idx_next, acc_next};
            word_reg.phase <= start_phase + use_acc;
            word_reg.wave  <= wave;
            word_reg.index <= INDEX_W'(use_idx);
            word_reg.last  <= is_last;
        end
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

    a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (cur_idx == '0 && cur_acc == '0))
        else $error("state did not wrap after the last sample of a window");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_last && !restart) |=> (cur_idx == $past(cur_idx) + IDX_W'(1)))
        else $error("sample index did not advance by one");

    a_ram_matches_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (init_reg && !wr_last_reg) |-> (ram_rdata == fwd_reg))
        else $error("state RAM read disagrees with the last written word");

    a_hold_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (init_reg && !accept) |=> (cur_state == $past(cur_state)))
        else $error("state changed without an accepted word");

endmodule

/* rtl/mwo_shape.sv */
// Shaping stages: quarter-wave sine lookup or direct waveform arithmetic, then
// rounding and saturation into the output register. Uses mwo_pkg.
module mwo_shape
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   word_valid,
    output logic                   word_ready,
    input  phase_word_t            word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] sample,
    output logic [INDEX_W-1:0]     sample_index,
    output logic                   last
);

    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int ROM_N = (1 << QB) + 1;
    localparam int SH    = 32 - SAMPLE_BITS;
    localparam int V_W   = 35;

    localparam logic [QB:0]            ROM_TOP = {1'b1, {QB{1'b0}}};
    localparam logic signed [V_W-1:0]  HALF    = 35'sd2147483648;
    localparam logic signed [V_W-1:0]  RND     = 35'sd1 <<< (SH - 1);
    localparam logic signed [V_W-1:0]  S_HI    = (35'sd1 <<< (SAMPLE_BITS - 1)) - 35'sd1;
    localparam logic signed [V_W-1:0]  S_LO    = -(35'sd1 <<< (SAMPLE_BITS - 1));

    // Quarter-wave table, one extra entry for the full-scale point.
    logic [31:0] rom [ROM_N];

    for (genvar g = 0; g < ROM_N; g++)
    begin : g_rom
        assign rom[g] = 32'(quarter_sine(64'(g) << (30 - QB)));
    end

    logic [PHASE_W-1:0]    ph;
    logic [PHASE_W-1:0]    tri_ph;
    logic [1:0]            quad;
    logic [QB-1:0]         pos;
    logic [QB:0]           rom_idx;
    logic                  is_sine;
    logic signed [V_W-1:0] tri_d;
    logic signed [V_W-1:0] tri_a;
    logic signed [V_W-1:0] other_val;
    logic                  ready1;
    logic                  ready2;

    logic                  valid1_reg;
    logic [31:0]           rom_q_reg;
    logic                  neg_reg;
    logic                  sine_reg;
    logic signed [V_W-1:0] other_reg;
    logic [INDEX_W-1:0]    index1_reg;
    logic                  last1_reg;

    logic signed [V_W-1:0] mag;
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] rounded;
    logic signed [V_W-1:0] sat;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic                   last_reg;

    assign ready2     = !out_valid_reg || out_ready;
    assign ready1     = !valid1_reg || ready2;
    assign word_ready = ready1;

    always_comb
    begin
        ph      = (word.wave == WAVE_COSINE) ? word.phase + QUARTER_CYCLE : word.phase;
        quad    = ph[31:30];
        pos     = ph[29 -: QB];
        // Odd quadrants run the quarter wave backward.
        rom_idx = quad[0] ? ROM_TOP - {1'b0, pos} : {1'b0, pos};

        tri_ph = word.phase + QUARTER_CYCLE;
        tri_d  = $signed({3'b000, tri_ph}) - HALF;
        tri_a  = (tri_d < 0) ? -tri_d : tri_d;

        is_sine   = 1'b0;
        other_val = '0;
        case (word.wave)
            WAVE_TRIANGLE: other_val = (tri_a <<< 1) - HALF;
            WAVE_SQUARE:   other_val = word.phase[31] ? HALF : -HALF;
            WAVE_SAWTOOTH: other_val = $signed({3'b000, word.phase}) - HALF;
            default:       is_sine   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                valid1_reg <= word_valid;
            end
            if (ready2)
            begin
                out_valid_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && word_valid)
        begin
            rom_q_reg  <= rom[rom_idx];
            neg_reg    <= quad[1];
            sine_reg   <= is_sine;
            other_reg  <= other_val;
            index1_reg <= word.index;
            last1_reg  <= word.last;
        end
    end

    always_comb
    begin
        mag     = $signed({2'b00, rom_q_reg, 1'b0});
        v       = sine_reg ? (neg_reg ? -mag : mag) : other_reg;
        rounded = (v + RND) >>> SH;
        if (rounded > S_HI)
        begin
            sat = S_HI;
        end
        else if (rounded < S_LO)
        begin
            sat = S_LO;
        end
        else
        begin
            sat = rounded;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && valid1_reg)
        begin
            sample_reg <= sat[SAMPLE_BITS-1:0];
            index_reg  <= index1_reg;
            last_reg   <= last1_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign sample_index = index_reg;
    assign last         = last_reg;

    a_sine_table_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && sine_reg && !neg_reg) |-> (v >= 0))
        else $error("positive half of the sine produced a negative value");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(sample_reg)
                                           && $stable(index_reg)))
        else $error("output word changed while stalled");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && !ready2) |=> (valid1_reg && $stable(index1_reg)))
        else $error("middle stage lost its word during a stall");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the multi-waveform oscillator.
// Drives restart words, predicts every sample and compares the output stream.
// Depends on rtl/mwo_pkg.sv and rtl/multi_waveform_oscillator.sv.
module tb
    import mwo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W      = ((SAMPLE_BITS_DEF + INDEX_W + 7) / 8) * 8;
    localparam int TBL        = SINE_TABLE_BITS_DEF;
    localparam int SHIFT      = 32 - SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 40;
    localparam longint LIMIT    = 300000;
    localparam longint HALF_Q31 = 64'sd2147483648;
    localparam logic [2:0] WAVE_UNLISTED = 3'd7;

    typedef struct {
        logic signed [SAMPLE_BITS_DEF-1:0] value;
        logic [INDEX_W-1:0]                pos;
        logic                              last;
    } osc_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;            // [0] restart
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;           // [15:0] sample, [25:16] sample_index, zero fill
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor copy of the registers and the window state.
    logic [31:0] cur_step = '0;
    logic [31:0] cur_offset = '0;
    logic [2:0]  cur_shape = '0;
    logic [10:0] cur_wlen = WLEN_RESET;
    int unsigned win_pos = 0;
    logic [31:0] step_sum = '0;

    logic        restart_q[$];
    osc_word_t   expected_samples[$];
    int unsigned mismatches = 0;
    longint      cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_taken = 1'b0;
    bit          hold_arm = 1'b0;
    bit          no_idle = 1'b0;

    multi_waveform_oscillator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // sin(pi/2 * u) in Q30 by Horner steps on the odd series, products truncated.
    function automatic logic [63:0] quarter_sin_poly(input logic [63:0] u);
        logic [63:0] coef[6];
        logic [63:0] u2;
        logic [63:0] acc;
        coef = '{64'd3864, 64'd172273, 64'd5026995, 64'd85569306,
                 64'd693598668, 64'd1686629713};
        u2 = (u * u) >> 30;
        acc = coef[0];
        for (int k = 1; k < 6; k++)
            acc = coef[k] - ((acc * u2) >> 30);
        return (acc * u) >> 30;
    endfunction

    function automatic longint sine_of_phase(input logic [31:0] ph);
        int unsigned addr;
        int unsigned quadrant;
        int unsigned pos;
        logic [63:0] u;
        logic [63:0] mag;
        addr = ph >> (32 - TBL);
        quadrant = (addr >> (TBL - 2)) & 3;
        pos = addr & ((1 << (TBL - 2)) - 1);
        u = 64'(pos) << (32 - TBL);
        if ((quadrant & 1) != 0)
            u = 64'd1073741824 - u;
        mag = quarter_sin_poly(u) << 1;
        return ((quadrant & 2) != 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint wave_value_q31(input logic [2:0] sel, input logic [31:0] ph);
        logic [31:0] shifted;
        longint d;
        shifted = ph + QUARTER_CYCLE;
        case (sel)
            WAVE_COSINE:   return sine_of_phase(shifted);
            WAVE_TRIANGLE:
            begin
                d = longint'(shifted) - HALF_Q31;
                if (d < 0)
                    d = -d;
                return 2 * d - HALF_Q31;
            end
            WAVE_SQUARE:   return ph[31] ? HALF_Q31 : -HALF_Q31;
            WAVE_SAWTOOTH: return longint'(ph) - HALF_Q31;
            default:       return sine_of_phase(ph);
        endcase
    endfunction

    // Round half up from Q31 to the sample width and clamp, so +1 lands on the maximum.
    function automatic logic signed [SAMPLE_BITS_DEF-1:0] q31_to_sample(input longint v);
        longint r;
        longint hi;
        hi = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
        r = ((v + 64'sd4294967296 + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT)
            - (64'sd4294967296 >>> SHIFT);
        if (r > hi)
            r = hi;
        if (r < -hi - 1)
            r = -hi - 1;
        return r[SAMPLE_BITS_DEF-1:0];
    endfunction

    task automatic predict_sample(input logic restart);
        int unsigned span;
        osc_word_t w;
        span = 32'(cur_wlen);
        if (span == 0)
            span = 1;
        if (span > WINDOW_MAX_DEF)
            span = WINDOW_MAX_DEF;
        if (restart)
        begin
            win_pos = 0;
            step_sum = '0;
        end
        w.value = q31_to_sample(wave_value_q31(cur_shape, cur_offset + step_sum));
        w.pos = win_pos[INDEX_W-1:0];
        w.last = (win_pos >= span - 1);
        expected_samples.push_back(w);
        if (w.last)
        begin
            win_pos = 0;
            step_sum = '0;
        end
        else
        begin
            win_pos++;
            step_sum += cur_step;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Mostly no gap, some short gaps, a few long ones.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a rising edge while the block is idle; the register takes the
    // value at the following edge.
    task automatic set_reg(input cfg_reg_t which, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        case (which)
            CFG_PHASE_STEP:    cur_step = value;
            CFG_START_PHASE:   cur_offset = value;
            CFG_WAVE_SELECT:   cur_shape = value[2:0];
            CFG_WINDOW_LENGTH: cur_wlen = value[10:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_words(input int unsigned n, input int unsigned restart_pct);
        @(negedge clk);
        repeat (n)
            restart_q.push_back($urandom_range(0, 99) < restart_pct);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (restart_q.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h00FF_FFFF);
            3: return 32'h1 << $urandom_range(20, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return WINDOW_MAX_DEF;
            2: return $urandom_range(WINDOW_MAX_DEF + 1, 2047);
            3: return 2047;
            4: return $urandom_range(100, WINDOW_MAX_DEF - 1);
            5: return 1;
            6: return $urandom_range(1, 64);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // Sender: offers queued words, holds a word until taken, and predicts on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_sample(s_tdata[0]);
            if (s_tvalid && !s_tready)
                ;
            else if (send_gap != 0 && !no_idle)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (restart_q.size() != 0)
            begin
                s_tdata <= {7'd0, restart_q.pop_front()};
                s_tvalid <= 1'b1;
                send_gap = no_idle ? 0 : idle_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: checks each accepted word against the oldest expected sample.
    always @(posedge clk)
    begin
        osc_word_t w;
        logic signed [SAMPLE_BITS_DEF-1:0] got_value;
        logic [INDEX_W-1:0] got_pos;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_value = m_tdata[SAMPLE_BITS_DEF-1:0];
                got_pos = m_tdata[SAMPLE_BITS_DEF +: INDEX_W];
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected word, sample %0d index %0d",
                                              got_value, got_pos));
                else
                begin
                    w = expected_samples.pop_front();
                    if (got_value !== w.value)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  got_value, w.value));
                    if (got_pos !== w.pos)
                        report_mismatch($sformatf("sample_index %0d, expected %0d",
                                                  got_pos, w.pos));
                    if (m_tlast !== w.last)
                        report_mismatch($sformatf("last %b, expected %b", m_tlast, w.last));
                end
                stall_left = no_idle ? 0 : idle_len();
            end
            if (hold_arm && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left != 0 && !no_idle)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        wave_t shapes[5];
        int unsigned n;
        int unsigned sent;
        int unsigned phase_no;
        shapes = '{WAVE_SINE, WAVE_COSINE, WAVE_TRIANGLE, WAVE_SQUARE, WAVE_SAWTOOTH};
        sent = 0;
        phase_no = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // One sample straight out of reset.
        push_words(1, 0);
        wait_idle();

        // Quarter-cycle steps over a window of four hit zero and both extremes of sine,
        // cosine and triangle; the last pass uses an unlisted selection, which means sine.
        @(posedge clk);
        set_reg(CFG_WINDOW_LENGTH, 4);
        set_reg(CFG_PHASE_STEP, QUARTER_CYCLE);
        set_reg(CFG_START_PHASE, 32'h0);
        cfg_we <= 1'b0;
        for (int k = 0; k < 6; k++)
        begin
            @(posedge clk);
            set_reg(CFG_WAVE_SELECT, (k < 5) ? 32'(shapes[k]) : 32'(WAVE_UNLISTED));
            cfg_we <= 1'b0;
            @(negedge clk);
            restart_q.push_back(1'b1);
            if (k < 5)
                push_words(3, 0);
            wait_idle();
        end

        // A zero window length acts as one sample, so every sample is last.
        @(posedge clk);
        set_reg(CFG_WINDOW_LENGTH, 0);
        set_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        set_reg(CFG_START_PHASE, 32'hFFFF_FFFF);
        set_reg(CFG_WAVE_SELECT, 32'(WAVE_TRIANGLE));
        cfg_we <= 1'b0;
        push_words(2, 0);
        wait_idle();

        // Shrinking the window below the current index ends the window at once.
        @(posedge clk);
        set_reg(CFG_WINDOW_LENGTH, WINDOW_MAX_DEF);
        cfg_we <= 1'b0;
        push_words(3, 0);
        wait_idle();
        @(posedge clk);
        set_reg(CFG_WINDOW_LENGTH, 2);
        cfg_we <= 1'b0;
        push_words(1, 0);
        wait_idle();

        // Random phases, each with a fresh mix of register values.
        while (sent < RANDOM_ITEMS)
        begin
            @(posedge clk);
            if (phase_no == 0 || $urandom_range(0, 9) < 6)
                set_reg(CFG_PHASE_STEP, pick_step());
            if (phase_no == 0 || $urandom_range(0, 9) < 5)
                set_reg(CFG_START_PHASE, ($urandom_range(0, 3) == 0)
                                         ? {32{$urandom_range(0, 1) == 1}} : $urandom());
            if (phase_no == 0 || $urandom_range(0, 9) < 6)
                set_reg(CFG_WAVE_SELECT, $urandom_range(0, 7));
            if (phase_no == 0 || $urandom_range(0, 9) < 6)
                set_reg(CFG_WINDOW_LENGTH, pick_window());
            cfg_we <= 1'b0;
            n = (phase_no == 3) ? 120 : $urandom_range(10, 60);
            @(negedge clk);
            no_idle = (phase_no % 4 == 1);
            // In this phase the receiver stops for a long stretch while words
            // keep coming, so the pipeline fills and the input stalls.
            hold_arm = (phase_no == 3);
            push_words(n, 5);
            sent += n;
            phase_no++;
            wait_idle();
        end

        no_idle = 1'b0;
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
